@@ rtl/bedc_pkg.sv @@
`default_nettype none

package bedc_pkg;

    // Fixed field widths
    localparam int K_W    = 6;   // target distance width
    localparam int VAL_W  = 7;   // cell value width, holds k+1 up to 64
    localparam int CHAR_W = 8;   // character field width on the stream

    localparam logic [K_W-1:0] K_RESET  = 6'd7;
    localparam logic [K_W-1:0] DIST_MAX = 6'd63;

    // Operation codes carried in s_tuser
    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // store the accepted request
        logic set_cap;      // early false: result is k+1
        logic init_wr;      // write row zero cell at col index
        logic read_a;       // fetch first word character for this row
        logic step;         // issue one cell of the current row
        logic load_result;  // move result to output register, clear pair
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic early;        // overflow or length difference above k
        logic out_busy;     // output register holds an untaken result
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/banded_edit_distance_check_unit.sv @@
`default_nettype none

// Banded edit distance checker. Load the first word with s_tuser = 0, one
// character per request, and close it with s_tlast; load the second word with
// s_tuser = 1. The request that carries s_tlast on the second word starts the
// compute and yields exactly one result: whether the Levenshtein distance is
// exactly target_distance (k), the distance saturated at k+1 (read as 63 when
// k+1 is 64), and an overflow flag for a word that tried to grow past MAX_LEN
// characters (excess characters are dropped, the match is then false). Only
// the band |i - j| <= k is evaluated; cells outside it count as k+1, and a
// length difference above k gives an early false. A compute first checks for
// an early false, which goes straight to the result; otherwise it writes row
// zero of the row store, then for each character of the first word starts a
// row and steps along it; after the last row it drains the last cell. The
// walk runs on the single row store, which reads one cell and writes one cell
// per cycle while a row is stepped. Input is held off during a compute; the
// finished result waits in an output register, and new words load while it
// is not yet taken. Write cfg_wdata only while the block idles.
module banded_edit_distance_check_unit
    import bedc_pkg::*;
#(
    parameter int MAX_LEN   = 32,
    parameter int CHAR_BITS = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration: target_distance
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    // input requests
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] character
    input  wire logic [0:0] s_tuser,   // [0] operation
    input  wire logic       s_tlast,   // last character of this word
    // results
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] is_exactly_k, [6:1] distance, [7] overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [LEN_W-1:0] m_len, n_len;
    logic [LEN_W-1:0] row_idx, col_idx;

    // Sequence loading, row walk and result hand-off
    bedc_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_last  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .m_len    (m_len),
        .n_len    (n_len),
        .cmd      (cmd),
        .row_idx  (row_idx),
        .col_idx  (col_idx)
    );

    // Hold the words, the row store, the cell update and the output register
    bedc_datapath #(.MAX_LEN(MAX_LEN), .CHAR_BITS(CHAR_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tuser[0]),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .status    (status),
        .m_len     (m_len),
        .n_len     (n_len),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/bedc_ram.sv @@
`default_nettype none

module bedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/bedc_datapath.sv @@
`default_nettype none

module bedc_datapath
    import bedc_pkg::*;
#(
    parameter int MAX_LEN   = 32,
    parameter int CHAR_BITS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [K_W-1:0]                    cfg_wdata,
    input  wire logic                              in_op,
    input  wire logic [CHAR_W-1:0]                 in_char,
    input  wire logic                              in_last,
    input  wire dp_cmd_t                           cmd,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]      row_idx,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]      col_idx,
    output dp_status_t                             status,
    output logic [$clog2(MAX_LEN+1)-1:0]           m_len,
    output logic [$clog2(MAX_LEN+1)-1:0]           n_len,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [7:0]                             m_tdata
);

    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int WADDR_W = $clog2(MAX_LEN);
    localparam int SB      = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
    localparam int CW      = (LEN_W > VAL_W) ? LEN_W : VAL_W;
    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

    logic [K_W-1:0]   k_reg;
    logic [VAL_W-1:0] cap;

    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;
    logic             ovf_reg, ovf_next;
    logic             first_closed_reg, first_closed_next;
    logic [LEN_W-1:0] len1_eff;

    logic             a_we, b_we;
    logic [SB-1:0]    char_st;
    logic [SB-1:0]    a_rdata, b_rdata;
    logic [LEN_W-1:0] a_raddr_full, b_raddr_full;
    logic [WADDR_W-1:0] b_raddr;

    logic [LEN_W-1:0] diff;

    logic             step_valid_reg;
    logic [LEN_W-1:0] i_d_reg, j_d_reg;
    logic [VAL_W-1:0] diag_reg, left_reg, last_value_reg;
    logic [VAL_W-1:0] up, diag_p, up_p, left_p, best;
    logic [VAL_W-1:0] i_cap, j_cap, cell_val;
    logic [LEN_W-1:0] off;
    logic             out_band;

    // Single row store, updated in place
    logic [VAL_W-1:0] row_rdata_w;
    logic             row_we;
    logic [LEN_W-1:0] row_waddr;
    logic [VAL_W-1:0] row_wdata;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic [K_W-1:0]   dist_sat;
    logic             is_k;

    assign cap = VAL_W'(k_reg) + VAL_W'(1);

    // Word loading and pair bookkeeping
    assign len1_eff = first_closed_reg ? '0 : first_len_reg;
    assign char_st  = in_char[SB-1:0];

    always_comb begin
        first_len_next    = first_len_reg;
        second_len_next   = second_len_reg;
        ovf_next          = ovf_reg;
        first_closed_next = first_closed_reg;
        a_we              = 1'b0;
        b_we              = 1'b0;
        if (cmd.load) begin
            if (in_op == OP_FIRST) begin
                if (first_closed_reg) begin
                    second_len_next = '0;
                    ovf_next        = 1'b0;
                end
                first_len_next = len1_eff;
                if (len1_eff < MAX_LEN_L) begin
                    a_we           = 1'b1;
                    first_len_next = len1_eff + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                first_closed_next = in_last;
            end else begin
                if (second_len_reg < MAX_LEN_L) begin
                    b_we            = 1'b1;
                    second_len_next = second_len_reg + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end else if (cmd.load_result) begin
            first_len_next    = '0;
            second_len_next   = '0;
            ovf_next          = 1'b0;
            first_closed_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg            <= K_RESET;
            first_len_reg    <= '0;
            second_len_reg   <= '0;
            ovf_reg          <= 1'b0;
            first_closed_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                k_reg <= cfg_wdata;
            end
            first_len_reg    <= first_len_next;
            second_len_reg   <= second_len_next;
            ovf_reg          <= ovf_next;
            first_closed_reg <= first_closed_next;
        end
    end

    assign m_len = first_len_reg;
    assign n_len = second_len_reg;

    assign diff = (first_len_reg > second_len_reg) ? (first_len_reg - second_len_reg)
                                                   : (second_len_reg - first_len_reg);
    assign status.early    = ovf_reg || (CW'(diff) > CW'(k_reg));
    assign status.out_busy = m_valid_reg && !m_tready;

    // Word stores
    assign a_raddr_full = row_idx - LEN_W'(1);
    assign b_raddr_full = col_idx - LEN_W'(1);
    assign b_raddr      = (col_idx == '0) ? '0 : b_raddr_full[WADDR_W-1:0];

    bedc_ram #(.WIDTH(SB), .DEPTH(MAX_LEN)) u_first_word (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (len1_eff[WADDR_W-1:0]),
        .wdata (char_st),
        .re    (cmd.read_a),
        .raddr (a_raddr_full[WADDR_W-1:0]),
        .rdata (a_rdata)
    );

    bedc_ram #(.WIDTH(SB), .DEPTH(MAX_LEN)) u_second_word (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (second_len_reg[WADDR_W-1:0]),
        .wdata (char_st),
        .re    (cmd.step),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Cell update, one cell per cycle while a row is stepped, in the cycle after the issued read
    assign up     = row_rdata_w;
    assign diag_p = diag_reg + VAL_W'(a_rdata != b_rdata);
    assign up_p   = up + VAL_W'(1);
    assign left_p = left_reg + VAL_W'(1);

    always_comb begin
        best = diag_p;
        if (up_p < best) begin
            best = up_p;
        end
        if (left_p < best) begin
            best = left_p;
        end
        if (cap < best) begin
            best = cap;
        end
    end

    assign off      = (i_d_reg > j_d_reg) ? (i_d_reg - j_d_reg) : (j_d_reg - i_d_reg);
    assign out_band = CW'(off) > CW'(k_reg);
    assign i_cap    = (CW'(i_d_reg) < CW'(cap)) ? VAL_W'(i_d_reg) : cap;
    assign j_cap    = (CW'(col_idx) < CW'(cap)) ? VAL_W'(col_idx) : cap;

    always_comb begin
        if (j_d_reg == '0) begin
            cell_val = i_cap;
        end else if (out_band) begin
            cell_val = cap;
        end else begin
            cell_val = best;
        end
    end

    assign row_we    = cmd.init_wr || step_valid_reg;
    assign row_waddr = step_valid_reg ? j_d_reg : col_idx;
    assign row_wdata = step_valid_reg ? cell_val : j_cap;

    bedc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN + 1)) u_row (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (cmd.step),
        .raddr (col_idx),
        .rdata (row_rdata_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_valid_reg <= 1'b0;
        end else begin
            step_valid_reg <= cmd.step;
        end
        if (cmd.step) begin
            i_d_reg <= row_idx;
            j_d_reg <= col_idx;
        end
        if (step_valid_reg) begin
            diag_reg <= up;
            left_reg <= cell_val;
        end
        if (cmd.set_cap) begin
            last_value_reg <= cap;
        end else if (step_valid_reg) begin
            last_value_reg <= cell_val;
        end else if (cmd.init_wr) begin
            last_value_reg <= j_cap;
        end
    end

    // Output register
    assign dist_sat = (last_value_reg > VAL_W'(DIST_MAX)) ? DIST_MAX : last_value_reg[K_W-1:0];
    assign is_k     = !ovf_reg && (last_value_reg == VAL_W'(k_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_result) begin
            m_data_reg <= {ovf_reg, dist_sat, is_k};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cell_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        step_valid_reg |-> (cell_val <= cap))
        else $error("cell value above k+1");

    a_pair_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> (first_len_reg == '0 && second_len_reg == '0 && !ovf_reg))
        else $error("pair not cleared after result");

endmodule

`default_nettype wire

@@ rtl/bedc_ctrl.sv @@
`default_nettype none

module bedc_ctrl
    import bedc_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          in_op,
    input  wire logic                          in_last,
    output logic                               s_tready,
    input  wire dp_status_t                    status,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]  m_len,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]  n_len,
    output dp_cmd_t                            cmd,
    output logic [$clog2(MAX_LEN+1)-1:0]       row_idx,
    output logic [$clog2(MAX_LEN+1)-1:0]       col_idx
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_ROW_START,
        S_ROW_STEP,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] row_reg, row_next;
    logic [LEN_W-1:0] col_reg, col_next;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (in_op == OP_SECOND && in_last) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (status.early) begin
                    cmd.set_cap = 1'b1;
                    state_next  = S_RESULT;
                end else begin
                    col_next   = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init_wr = 1'b1;
                if (col_reg == n_len) begin
                    if (m_len == '0) begin
                        state_next = S_RESULT;
                    end else begin
                        row_next   = LEN_W'(1);
                        state_next = S_ROW_START;
                    end
                end else begin
                    col_next = col_reg + LEN_W'(1);
                end
            end
            S_ROW_START: begin
                cmd.read_a = 1'b1;
                col_next   = '0;
                state_next = S_ROW_STEP;
            end
            S_ROW_STEP: begin
                cmd.step = 1'b1;
                if (col_reg == n_len) begin
                    if (row_reg == m_len) begin
                        state_next = S_DRAIN;
                    end else begin
                        row_next   = row_reg + LEN_W'(1);
                        state_next = S_ROW_START;
                    end
                end else begin
                    col_next = col_reg + LEN_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!status.out_busy) begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    assign row_idx = row_reg;
    assign col_idx = col_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> !status.out_busy)
        else $error("result loaded over an untaken result");

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROW_STEP || state_reg == S_INIT) |-> (col_reg <= n_len))
        else $error("column beyond second word length");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROW_START || state_reg == S_ROW_STEP)
            |-> (row_reg != '0 && row_reg <= m_len))
        else $error("row beyond first word length");

endmodule

`default_nettype wire
